[rtl/core/sdf_pkg.sv]
// Shared types and constants for the signed decimal formatter.
// Used by sdf_bcd_unit, signed_decimal_formatter_top and sdf_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

    localparam int MAG_W      = 32;
    localparam int PAD_W      = 5;
    localparam int CAP_W      = 7;
    localparam int CODE_W     = 7;
    localparam int TL_W       = 5;
    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIG_W;
    localparam int BIT_CNT_W  = $clog2(MAG_W);

    localparam logic [CODE_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CODE_W-1:0] CH_MINUS = 7'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_CHECK,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT,
        ST_REJECT
    } state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_digit;
    } bcd_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/signed_decimal_formatter_top.sv]
// Top level of the signed decimal formatter: request capture, sequencing and output.
// Depends on sdf_pkg and sdf_bcd_unit.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays high until the
// last character has been sent. The value's magnitude goes through a bit-serial BCD
// converter at one bit per cycle, leading zero digits are dropped at one per cycle, a
// check state sizes the text and checks capacity, and the text then leaves one character
// per cycle on strobe, sign first. A rejected request gives a single result. Results
// cannot be held off: each is on the ports for exactly one cycle.
module signed_decimal_formatter_top #(
    parameter int MAX_TEXT     = 31,
    parameter int MIN_CAPACITY = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [sdf_pkg::MAG_W-1:0]  value,
    input  wire logic [sdf_pkg::PAD_W-1:0]  pad_width,
    input  wire logic [sdf_pkg::CAP_W-1:0]  buffer_capacity,
    output logic                            strobe,
    output logic      [sdf_pkg::CODE_W-1:0] code_unit,
    output logic                            last,
    output logic                            rejected,
    output logic      [sdf_pkg::TL_W-1:0]   text_length
);
    import sdf_pkg::*;

    localparam int LEN_W = $clog2(MAX_TEXT + 1);
    localparam int PW    = (LEN_W > PAD_W) ? LEN_W : PAD_W;
    localparam int CMP_W = (LEN_W > CAP_W) ? LEN_W : CAP_W;
    localparam int EXT_W = (LEN_W > TL_W) ? LEN_W : TL_W;

    state_t state_reg;
    state_t state_next;

    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [DIG_W-1:0]     dig_cnt_reg;
    logic [DIG_W-1:0]     dig_cnt_next;
    logic [LEN_W-1:0]     zeros_reg;
    logic [LEN_W-1:0]     zeros_next;
    logic [LEN_W-1:0]     pad_reg;
    logic [LEN_W-1:0]     pad_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [CAP_W-1:0]     cap_next;
    logic                 neg_reg;
    logic                 neg_next;

    logic                 strobe_reg;
    logic                 strobe_next;
    logic [CODE_W-1:0]    code_unit_reg;
    logic [CODE_W-1:0]    code_unit_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 rejected_reg;
    logic                 rejected_next;
    logic [TL_W-1:0]      text_length_reg;
    logic [TL_W-1:0]      text_length_next;

    bcd_ctrl_t            bcd_ctrl;
    logic [MAG_W-1:0]     mag_in;
    logic [DIG_W-1:0]     top_digit;

    logic                 accept;
    logic [PW-1:0]        pad_ext;
    logic [PW-1:0]        pad_sat;
    logic [LEN_W-1:0]     width_c;
    logic [LEN_W-1:0]     dig_ext;
    logic [LEN_W-1:0]     zeros_c;
    logic [LEN_W-1:0]     len_c;
    logic                 reject_c;
    logic [EXT_W-1:0]     len_c_ext;

    sdf_bcd_unit u_bcd (
        .clk       (clk),
        .ctrl      (bcd_ctrl),
        .mag       (mag_in),
        .top_digit (top_digit)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign mag_in = value[MAG_W-1] ? (MAG_W'(0) - value) : value;

    assign pad_ext = PW'(pad_width);
    assign pad_sat = (pad_ext > PW'(MAX_TEXT)) ? PW'(MAX_TEXT) : pad_ext;

    // The sign takes one place of the padded width.
    assign width_c  = (neg_reg && (pad_reg != '0)) ? pad_reg - LEN_W'(1) : pad_reg;
    assign dig_ext  = LEN_W'(dig_cnt_reg);
    assign zeros_c  = (width_c > dig_ext) ? width_c - dig_ext : '0;
    assign len_c    = dig_ext + zeros_c + LEN_W'(neg_reg);
    assign reject_c = (CMP_W'(cap_reg) < CMP_W'(MIN_CAPACITY))
                   || (CMP_W'(len_c) >= CMP_W'(cap_reg));
    assign len_c_ext = EXT_W'(len_c);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == BIT_CNT_W'(MAG_W - 1))
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (!((dig_cnt_reg > DIG_W'(1)) && (top_digit == '0)))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (reject_c)
                    state_next = ST_REJECT;
                else if (neg_reg)
                    state_next = ST_SIGN;
                else if (zeros_c != '0)
                    state_next = ST_PAD;
                else
                    state_next = ST_DIGIT;
            end
            ST_SIGN:
            begin
                state_next = (zeros_reg != '0) ? ST_PAD : ST_DIGIT;
            end
            ST_PAD:
            begin
                if (zeros_reg == LEN_W'(1))
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (dig_cnt_reg == DIG_W'(1))
                    state_next = ST_IDLE;
            end
            ST_REJECT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bcd_ctrl         = '0;
        bit_cnt_next     = bit_cnt_reg;
        dig_cnt_next     = dig_cnt_reg;
        zeros_next       = zeros_reg;
        pad_next         = pad_reg;
        cap_next         = cap_reg;
        neg_next         = neg_reg;
        strobe_next      = 1'b0;
        code_unit_next   = '0;
        last_next        = 1'b0;
        rejected_next    = 1'b0;
        text_length_next = text_length_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bcd_ctrl.load = 1'b1;
                    bit_cnt_next  = '0;
                    neg_next      = value[MAG_W-1];
                    pad_next      = LEN_W'(pad_sat);
                    cap_next      = buffer_capacity;
                end
            end
            ST_CONV:
            begin
                bcd_ctrl.dabble = 1'b1;
                bit_cnt_next    = bit_cnt_reg + BIT_CNT_W'(1);
                dig_cnt_next    = DIG_W'(NUM_DIGITS);
            end
            ST_NORM:
            begin
                // Drop leading zero digits, keeping at least one digit.
                if ((dig_cnt_reg > DIG_W'(1)) && (top_digit == '0))
                begin
                    bcd_ctrl.shift_digit = 1'b1;
                    dig_cnt_next         = dig_cnt_reg - DIG_W'(1);
                end
            end
            ST_CHECK:
            begin
                zeros_next       = zeros_c;
                text_length_next = len_c_ext[TL_W-1:0];
            end
            ST_SIGN:
            begin
                strobe_next    = 1'b1;
                code_unit_next = CH_MINUS;
            end
            ST_PAD:
            begin
                strobe_next    = 1'b1;
                code_unit_next = CH_ZERO;
                zeros_next     = zeros_reg - LEN_W'(1);
            end
            ST_DIGIT:
            begin
                strobe_next          = 1'b1;
                code_unit_next       = CH_ZERO + CODE_W'(top_digit);
                last_next            = (dig_cnt_reg == DIG_W'(1));
                bcd_ctrl.shift_digit = 1'b1;
                dig_cnt_next         = dig_cnt_reg - DIG_W'(1);
            end
            ST_REJECT:
            begin
                strobe_next      = 1'b1;
                last_next        = 1'b1;
                rejected_next    = 1'b1;
                text_length_next = '0;
            end
            default:
            begin
                bcd_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg     <= bit_cnt_next;
        dig_cnt_reg     <= dig_cnt_next;
        zeros_reg       <= zeros_next;
        pad_reg         <= pad_next;
        cap_reg         <= cap_next;
        neg_reg         <= neg_next;
        code_unit_reg   <= code_unit_next;
        last_reg        <= last_next;
        rejected_reg    <= rejected_next;
        text_length_reg <= text_length_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign code_unit   = code_unit_reg;
    assign last        = last_reg;
    assign rejected    = rejected_reg;
    assign text_length = text_length_reg;

endmodule

`default_nettype wire

[rtl/core/sdf_bcd_unit.sv]
// Bit-serial binary to BCD converter with a digit shift-out path.
// Depends on sdf_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sdf_bcd_unit (
    input  wire logic                      clk,
    input  wire sdf_pkg::bcd_ctrl_t        ctrl,
    input  wire logic [sdf_pkg::MAG_W-1:0] mag,
    output logic      [sdf_pkg::DIG_W-1:0] top_digit
);
    import sdf_pkg::*;

    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] mag_next;
    logic [BCD_W-1:0] adj;

    // Add-3 correction on every digit of five or more before each shift.
    always_comb
    begin
        logic [DIG_W-1:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[i*DIG_W +: DIG_W];
            adj[i*DIG_W +: DIG_W] = (d >= DIG_W'(5)) ? d + DIG_W'(3) : d;
        end
    end

    always_comb
    begin
        bcd_next = bcd_reg;
        mag_next = mag_reg;
        if (ctrl.load)
        begin
            bcd_next = '0;
            mag_next = mag;
        end
        else if (ctrl.dabble)
        begin
            bcd_next = {adj[BCD_W-2:0], mag_reg[MAG_W-1]};
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-DIG_W-1:0], DIG_W'(0)};
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        mag_reg <= mag_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DIG_W];

endmodule

`default_nettype wire

[rtl/core/sdf_checker.sv]
// Port-level checks for signed_decimal_formatter_top, attached by bind.
// Depends on sdf_pkg for field widths and character codes.
`timescale 1ns / 1ps
`default_nettype none

module sdf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       strobe,
    input wire logic [sdf_pkg::CODE_W-1:0] code_unit,
    input wire logic                       last,
    input wire logic                       rejected,
    input wire logic [sdf_pkg::TL_W-1:0]   text_length
);
    import sdf_pkg::*;

    // A rejected request gives a single empty result.
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && rejected |-> last && (text_length == '0) && (code_unit == '0))
        else $error("reject result is malformed");

    // The characters of one text leave on consecutive cycles with a steady length.
    a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && !rejected && (text_length == $past(text_length)))
        else $error("text interrupted or length changed");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !rejected |-> ((code_unit >= CH_ZERO) && (code_unit <= CH_ZERO + 7'd9))
                             || (code_unit == CH_MINUS))
        else $error("code unit is not a digit or minus sign");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("still busy when the final result is shown");

endmodule

bind signed_decimal_formatter_top sdf_checker u_sdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .code_unit   (code_unit),
    .last        (last),
    .rejected    (rejected),
    .text_length (text_length)
);

`default_nettype wire
